>>> rtl/keypad_thermostat_hysteresis_top_defines.svh
// assertion macros for the keypad thermostat checker
// depends on nothing; expects clock and reset in the scope of use
`ifndef KEYPAD_THERMOSTAT_HYSTERESIS_TOP_DEFINES_SVH
`define KEYPAD_THERMOSTAT_HYSTERESIS_TOP_DEFINES_SVH

// same-cycle implication
`define KTH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KTH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/kth_pkg.sv
// shared types and constants of the keypad thermostat
// depends on nothing
package kth_pkg;

   localparam int KEY_W  = 3;
   localparam int TEMP_W = 12;
   localparam int SP_W   = 10;
   localparam int HYST_W = 7;
   localparam int ICON_W = 4;

   localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
   localparam logic [KEY_W-1:0] KEY_SET  = 3'd1;
   localparam logic [KEY_W-1:0] KEY_UP   = 3'd2;
   localparam logic [KEY_W-1:0] KEY_DOWN = 3'd3;
   localparam logic [KEY_W-1:0] KEY_RST  = 3'd4;

   localparam logic signed [SP_W-1:0] SP_STEP    = 10'sd5;
   localparam logic signed [SP_W-1:0] SP_MAX     = 10'sd300;
   localparam logic signed [SP_W-1:0] SP_MIN     = -10'sd300;
   localparam logic signed [SP_W-1:0] SP_DEFAULT = -10'sd50;

   localparam logic [HYST_W-1:0] HYST_RESET = 7'd20;

   typedef struct packed {
      logic signed [TEMP_W-1:0] shown_value;
      logic                     refresh;
      logic                     setting_mode;
      logic                     cool_on;
      logic                     fan_on;
      logic                     heat_on;
   } rsp_type;

endpackage

>>> rtl/kth_core.sv
// thermostat state and single-pass step logic for one polled item
// depends on kth_pkg
module kth_core import kth_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [KEY_W-1:0]         key_code,
   input  logic signed [TEMP_W-1:0] temperature,
   input  logic [HYST_W-1:0]        hyst,
   output rsp_type                  result
);

   logic                     mode_ff, mode_in;
   logic signed [SP_W-1:0]   sp_ff, sp_in;
   logic                     cool_ff, cool_in;
   logic                     fan_ff, fan_in;
   logic                     heat_ff, heat_in;
   logic signed [TEMP_W-1:0] last_shown_ff, last_shown_in;
   logic [ICON_W-1:0]        last_icons_ff, last_icons_in;
   logic                     force_ff;

   logic                     force_now;
   logic signed [SP_W:0]     sp_sum;
   logic signed [TEMP_W:0]   band_hi, band_lo, temp_x, sp_x, hyst_x;
   logic signed [TEMP_W-1:0] shown;
   logic [ICON_W-1:0]        icons;
   logic                     refresh;

   always_comb begin
      mode_in   = mode_ff;
      sp_in     = sp_ff;
      cool_in   = cool_ff;
      fan_in    = fan_ff;
      heat_in   = heat_ff;
      force_now = force_ff;
      sp_sum    = {sp_ff[SP_W-1], sp_ff};

      if (key_code == KEY_SET) begin
         mode_in   = ~mode_ff;
         force_now = 1'b1;
      end
      // setpoint step only in setting mode, then clamp
      if (mode_in) begin
         if (key_code == KEY_UP) begin
            sp_sum = {sp_ff[SP_W-1], sp_ff} + {SP_STEP[SP_W-1], SP_STEP};
         end else if (key_code == KEY_DOWN) begin
            sp_sum = {sp_ff[SP_W-1], sp_ff} - {SP_STEP[SP_W-1], SP_STEP};
         end
         if (sp_sum > $signed({SP_MAX[SP_W-1], SP_MAX})) begin
            sp_in = SP_MAX;
         end else if (sp_sum < $signed({SP_MIN[SP_W-1], SP_MIN})) begin
            sp_in = SP_MIN;
         end else begin
            sp_in = sp_sum[SP_W-1:0];
         end
      end
      if (key_code == KEY_RST) begin
         mode_in   = 1'b0;
         sp_in     = SP_DEFAULT;
         force_now = 1'b1;
      end

      // strict hysteresis band
      temp_x  = {temperature[TEMP_W-1], temperature};
      sp_x    = {{(TEMP_W+1-SP_W){sp_in[SP_W-1]}}, sp_in};
      hyst_x  = {{(TEMP_W+1-HYST_W){1'b0}}, hyst};
      band_hi = sp_x + hyst_x;
      band_lo = sp_x - hyst_x;
      if (!mode_in) begin
         if (temp_x > band_hi) begin
            cool_in = 1'b1;
            fan_in  = 1'b1;
            heat_in = 1'b0;
         end else if (temp_x < band_lo) begin
            cool_in = 1'b0;
            fan_in  = 1'b0;
            heat_in = 1'b1;
         end
      end

      shown   = mode_in ? {{(TEMP_W-SP_W){sp_in[SP_W-1]}}, sp_in} : temperature;
      icons   = {mode_in, cool_in, fan_in, heat_in};
      refresh = force_now || (shown != last_shown_ff) || (icons != last_icons_ff);

      last_shown_in = refresh ? shown : last_shown_ff;
      last_icons_in = refresh ? icons : last_icons_ff;

      result.shown_value  = shown;
      result.refresh      = refresh;
      result.setting_mode = mode_in;
      result.cool_on      = cool_in;
      result.fan_on       = fan_in;
      result.heat_on      = heat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         sp_ff         <= SP_DEFAULT;
         cool_ff       <= 1'b0;
         fan_ff        <= 1'b0;
         heat_ff       <= 1'b0;
         last_shown_ff <= '0;
         last_icons_ff <= '0;
         force_ff      <= 1'b1;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         sp_ff         <= sp_in;
         cool_ff       <= cool_in;
         fan_ff        <= fan_in;
         heat_ff       <= heat_in;
         last_shown_ff <= last_shown_in;
         last_icons_ff <= last_icons_in;
         // any pending force is consumed by the item shown now
         force_ff      <= 1'b0;
      end
   end

endmodule

>>> rtl/keypad_thermostat_hysteresis_top.sv
// keypad thermostat with hysteresis: input register, step core, result register
// depends on kth_pkg and kth_core
// throughput: one item per cycle while rsp_ready stays high; the result register frees
// as soon as it is taken
// reset (synchronous, active high): run mode, setpoint -5.0, marks off,
// hysteresis 2.0, first item forces refresh, both pipeline stages empty
module keypad_thermostat_hysteresis_top import kth_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_wr_en,
   input  logic [HYST_W-1:0]        csr_wr_data,
   // poll items
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KEY_W-1:0]         req_key_code,
   input  logic signed [TEMP_W-1:0] req_temperature,
   // results
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_shown_value,
   output logic                     rsp_refresh,
   output logic                     rsp_setting_mode,
   output logic                     rsp_cool_on,
   output logic                     rsp_fan_on,
   output logic                     rsp_heat_on
);

   // hysteresis half-width register
   logic [HYST_W-1:0] hyst_ff;

   // input stage
   logic                     in_valid_ff;
   logic [KEY_W-1:0]         in_key_ff;
   logic signed [TEMP_W-1:0] in_temp_ff;

   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_result;

   logic advance;
   logic req_take;

   // the input item moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff <= HYST_RESET;
      end else if (csr_wr_en) begin
         hyst_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_key_ff  <= req_key_code;
         in_temp_ff <= req_temperature;
      end
   end

   // state updates exactly when the item lands in the result register
   kth_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .key_code    (in_key_ff),
      .temperature (in_temp_ff),
      .hyst        (hyst_ff),
      .result      (core_result)
   );

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_shown_value  = out_data_ff.shown_value;
   assign rsp_refresh      = out_data_ff.refresh;
   assign rsp_setting_mode = out_data_ff.setting_mode;
   assign rsp_cool_on      = out_data_ff.cool_on;
   assign rsp_fan_on       = out_data_ff.fan_on;
   assign rsp_heat_on      = out_data_ff.heat_on;

endmodule

>>> rtl/kth_checker.sv
// port-level checks for the keypad thermostat, bound to the top level
// depends on kth_pkg and keypad_thermostat_hysteresis_top_defines.svh
`include "keypad_thermostat_hysteresis_top_defines.svh"

module kth_checker import kth_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] rsp_shown_value,
   input logic                     rsp_refresh,
   input logic                     rsp_setting_mode,
   input logic                     rsp_cool_on,
   input logic                     rsp_fan_on,
   input logic                     rsp_heat_on
);

   logic signed [TEMP_W-1:0] sp_max_x, sp_min_x;

   assign sp_max_x = {{(TEMP_W-SP_W){SP_MAX[SP_W-1]}}, SP_MAX};
   assign sp_min_x = {{(TEMP_W-SP_W){SP_MIN[SP_W-1]}}, SP_MIN};

   // a stalled item stays valid
   `KTH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // a stalled item keeps its shown value, refresh and setting mode
   `KTH_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(rsp_shown_value) && $stable(rsp_refresh) && $stable(rsp_setting_mode),
      "result payload changed while stalled")

   // in setting mode the shown setpoint stays inside its clamp
   `KTH_ASSERT_NOW(a_sp_range, rsp_valid && rsp_setting_mode,
      (rsp_shown_value <= sp_max_x) && (rsp_shown_value >= sp_min_x),
      "setpoint outside clamp")

   // cooling and fan move together and never with heating
   `KTH_ASSERT_NOW(a_marks, rsp_valid,
      (rsp_cool_on == rsp_fan_on) && !(rsp_cool_on && rsp_heat_on),
      "inconsistent cool, fan and heat marks")

   // a valid result sampled right after reset must refresh the display
   `KTH_ASSERT_NOW(a_first_refresh, rsp_valid && $past(reset), rsp_refresh,
      "first item not refreshed")

endmodule

bind keypad_thermostat_hysteresis_top kth_checker u_kth_checker (.*);

>>> tb/kth_scoreboard_pkg.sv
// scoreboard for the keypad thermostat: predicts each result and checks the block's output
// depends on kth_pkg for the result struct, key codes and setpoint constants
`timescale 1ns / 100ps

package kth_scoreboard_pkg;
   import kth_pkg::*;

   class thermostat_scoreboard;
      int unsigned hyst;
      bit          setting;
      int          setpoint;
      bit          cool;
      bit          fan;
      bit          heat;
      logic signed [TEMP_W-1:0] last_shown;
      logic [ICON_W-1:0]        last_icons;
      bit          force_refresh;
      rsp_type     expected_q[$];
      int unsigned errors;

      function new();
         hyst          = HYST_RESET;
         setting       = 1'b0;
         setpoint      = SP_DEFAULT;
         cool          = 1'b0;
         fan           = 1'b0;
         heat          = 1'b0;
         last_shown    = '0;
         last_icons    = '0;
         force_refresh = 1'b1;
         errors        = 0;
      endfunction

      function void set_hysteresis(logic [HYST_W-1:0] value);
         hyst = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // step the thermostat for one accepted poll item
      function void note_poll(logic [KEY_W-1:0] key, logic signed [TEMP_W-1:0] temp);
         int t;
         int h;
         logic signed [TEMP_W-1:0] shown;
         logic [ICON_W-1:0] icons;
         rsp_type r;
         t = temp;
         h = hyst;
         if (key == KEY_SET) begin
            setting = !setting;
            force_refresh = 1'b1;
         end
         if (setting) begin
            if (key == KEY_UP) setpoint += SP_STEP;
            if (key == KEY_DOWN) setpoint -= SP_STEP;
            if (setpoint > SP_MAX) setpoint = SP_MAX;
            if (setpoint < SP_MIN) setpoint = SP_MIN;
         end
         if (key == KEY_RST) begin
            setting = 1'b0;
            setpoint = SP_DEFAULT;
            force_refresh = 1'b1;
         end
         if (!setting) begin
            if (t > setpoint + h) begin
               cool = 1'b1;
               fan  = 1'b1;
               heat = 1'b0;
            end else if (t < setpoint - h) begin
               cool = 1'b0;
               fan  = 1'b0;
               heat = 1'b1;
            end
            shown = temp;
         end else begin
            shown = TEMP_W'(setpoint);
         end
         icons = {setting, cool, fan, heat};
         r.refresh = force_refresh || shown != last_shown || icons != last_icons;
         if (r.refresh) begin
            last_shown = shown;
            last_icons = icons;
            force_refresh = 1'b0;
         end
         r.shown_value  = shown;
         r.setting_mode = setting;
         r.cool_on      = cool;
         r.fan_on       = fan;
         r.heat_on      = heat;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string fname, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result item with no prediction waiting");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("shown_value", int'(want.shown_value), int'(got.shown_value));
         compare_field("refresh", want.refresh, got.refresh);
         compare_field("setting_mode", want.setting_mode, got.setting_mode);
         compare_field("cool_on", want.cool_on, got.cool_on);
         compare_field("fan_on", want.fan_on, got.fan_on);
         compare_field("heat_on", want.heat_on, got.heat_on);
      endfunction

      function void check_drained();
         if (expected_q.size() != 0) begin
            $error("%0d predicted result items never arrived", expected_q.size());
            errors++;
         end
      endfunction
   endclass

endpackage

>>> tb/tb_keypad_thermostat_hysteresis_top.sv
// testbench top for the keypad thermostat: directed polls, then random phases over
// several hysteresis settings; depends on kth_pkg, kth_scoreboard_pkg and the block itself
`timescale 1ns / 100ps

module tb_keypad_thermostat_hysteresis_top;
   import kth_pkg::*;
   import kth_scoreboard_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [HYST_W-1:0]        csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [KEY_W-1:0]         req_key_code = KEY_NONE;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0] rsp_shown_value;
   logic                     rsp_refresh;
   logic                     rsp_setting_mode;
   logic                     rsp_cool_on;
   logic                     rsp_fan_on;
   logic                     rsp_heat_on;

   thermostat_scoreboard sb;
   bit quiet = 1'b0;          // set during one phase: no idling on either side
   int polls_sent = 0;
   int hyst_plan[8] = '{0, 100, 27, 1, -1, 99, -1, 20};   // -1 picks a random width

   keypad_thermostat_hysteresis_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_code     (req_key_code),
      .req_temperature  (req_temperature),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shown_value  (rsp_shown_value),
      .rsp_refresh      (rsp_refresh),
      .rsp_setting_mode (rsp_setting_mode),
      .rsp_cool_on      (rsp_cool_on),
      .rsp_fan_on       (rsp_fan_on),
      .rsp_heat_on      (rsp_heat_on)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stalls at random, about 9 percent of the time
   always @(posedge clock) begin
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
   end

   // both handshakes are sampled at the edge, before any nonblocking update lands
   always @(posedge clock) begin
      rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready) sb.note_poll(req_key_code, req_temperature);
         if (rsp_valid && rsp_ready) begin
            got.shown_value  = rsp_shown_value;
            got.refresh      = rsp_refresh;
            got.setting_mode = rsp_setting_mode;
            got.cool_on      = rsp_cool_on;
            got.fan_on       = rsp_fan_on;
            got.heat_on      = rsp_heat_on;
            sb.check_result(got);
         end
      end
   end

   // present one poll item, with a random idle gap first unless quiet, and hold it until taken
   task automatic send_poll(logic [KEY_W-1:0] key, logic signed [TEMP_W-1:0] temp);
      if (!quiet) begin
         while ($urandom_range(99) < 9) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_key_code    <= key;
      req_temperature <= temp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      polls_sent++;
   endtask

   // stop sending and wait for every predicted result; every item yields one,
   // so an empty queue means the pipeline is empty too
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_hysteresis(logic [HYST_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_hysteresis(value);
   endtask

   // a temperature a little either side of the switching band, edges included
   function automatic logic signed [TEMP_W-1:0] near_band();
      int span;
      span = sb.hyst + 3;
      return TEMP_W'(sb.setpoint + int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [KEY_W-1:0] session_key();
      case ($urandom_range(5))
         0: return KEY_UP;
         1: return KEY_DOWN;
         2: return KEY_NONE;
         default: return 3'($urandom_range(7, 5));   // unused codes act as no key
      endcase
   endfunction

   // mostly well-formed sessions and band sweeps, with noise and broken sessions
   task automatic run_random(int target);
      int kind;
      int n;
      logic [KEY_W-1:0] dir;
      logic signed [TEMP_W-1:0] t;
      while (polls_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            // setting session, sometimes long enough to hit the setpoint clamp
            send_poll(KEY_SET, 12'($urandom_range(4095)));
            n   = ($urandom_range(9) == 0) ? $urandom_range(90, 55) : $urandom_range(12, 1);
            dir = $urandom_range(1) ? KEY_UP : KEY_DOWN;
            repeat (n) begin
               send_poll(($urandom_range(3) == 0) ? session_key() : dir,
                         12'($urandom_range(4095)));
            end
            send_poll(($urandom_range(7) == 0) ? KEY_RST : KEY_SET, near_band());
         end else if (kind < 75) begin
            // run mode sweep around the band, repeats let refresh drop
            n = $urandom_range(20, 4);
            t = near_band();
            repeat (n) begin
               if ($urandom_range(1)) t = near_band();
               send_poll(($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : KEY_NONE, t);
            end
         end else if (kind < 92) begin
            send_poll(3'($urandom_range(7)), 12'($urandom_range(4095)));
         end else begin
            send_poll(KEY_RST, 12'($urandom_range(4095)));
            repeat ($urandom_range(4, 1)) send_poll(KEY_NONE, near_band());
         end
      end
   endtask

   initial begin
      int target;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed polls at the reset width of 2.0 degrees, setpoint -5.0
      send_poll(KEY_NONE, 12'sd0);        // first poll forces refresh
      send_poll(KEY_NONE, 12'sd0);        // nothing changed, no refresh
      send_poll(KEY_NONE, 12'sd1250);     // hottest in range: cool and fan
      send_poll(KEY_NONE, -12'sd550);     // coldest in range: heat
      send_poll(KEY_NONE, -12'sd30);      // upper band edge holds
      send_poll(KEY_NONE, -12'sd29);      // just above the band
      send_poll(KEY_NONE, -12'sd70);      // lower band edge holds
      send_poll(KEY_NONE, -12'sd71);      // just below the band
      send_poll(KEY_UP, 12'sd0);          // up in run mode is ignored
      send_poll(KEY_DOWN, 12'h800);       // down ignored, most negative pattern
      send_poll(KEY_NONE, 12'h7ff);       // most positive pattern, no saturation
      send_poll(KEY_SET, 12'sd100);       // enter setting, no step this poll
      send_poll(KEY_UP, 12'sd0);
      send_poll(KEY_DOWN, 12'sd0);
      send_poll(KEY_DOWN, 12'sd0);
      send_poll(3'd5, 12'sd0);            // unused codes act as no key
      send_poll(3'd6, 12'sd0);
      send_poll(3'd7, 12'h800);
      send_poll(KEY_SET, 12'h800);        // back to run
      send_poll(KEY_SET, 12'sd0);
      send_poll(KEY_RST, 12'sd0);         // reset from setting mode
      send_poll(KEY_RST, 12'sd0);         // reset again in run mode
      send_poll(KEY_NONE, 12'hfff);
      wait_drained();

      // random phases, hysteresis rewritten only with the pipeline empty
      foreach (hyst_plan[p]) begin
         write_hysteresis((hyst_plan[p] < 0) ? 7'($urandom_range(100)) : 7'(hyst_plan[p]));
         quiet  = (p == 3);
         target = polls_sent + 244;
         if (p == 2) begin
            // sender holds off mid phase until every result is back
            run_random(polls_sent + 120);
            wait_drained();
         end
         run_random(target);
         wait_drained();
      end
      quiet = 1'b0;

      repeat (4) @(posedge clock);
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
